// ===== design/indexed_min_heap_queue_assert.svh =====
// Assertion macro used by the checker file of this block.
`ifndef INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define IMHQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("imhq assertion failed");

`endif

// ===== design/imhq_pkg.sv =====
package imhq_pkg;

    localparam int CAPACITY     = 1024;
    localparam int VERTEX_COUNT = 1024;
    localparam int KEY_W        = 32;
    localparam int VID_W        = 10;
    localparam int REQ_W        = 2;
    localparam int STAT_W       = 3;
    localparam int CNT_W        = 11;
    localparam int HADDR_W      = $clog2(CAPACITY);
    localparam int SLOT_W       = $clog2(CAPACITY + 1);
    localparam int CHILD_W      = SLOT_W + 1;
    localparam int PM_AW        = $clog2(VERTEX_COUNT);
    localparam int ENTRY_W      = KEY_W + VID_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_CHANGE  = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } t_status;

    typedef struct packed {
        logic    accept;
        logic    clr;
        logic    start_ins;
        logic    start_chg;
        logic    st_wr;
        t_status st_code;
        logic    ex_root;
        logic    ex_last;
        logic    up_rd;
        logic    up_move;
        logic    dn_rdl;
        logic    dn_rdr;
        logic    dn_move;
        logic    place;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic             clr_done;
        logic             in_range;
        logic             present;
        logic             full;
        logic             empty;
        logic             chg_ok;
        logic             cnt_gt1;
        logic             s_gt1;
        logic             up_less;
        logic             has_child;
        logic             dn_more;
        logic             is_chg;
        logic             out_free;
        logic [REQ_W-1:0] req;
    } t_stat;

endpackage

// ===== design/imhq_if.sv =====
interface imhq_req_if;
    logic                       valid;
    logic                       ready;
    logic [imhq_pkg::REQ_W-1:0] req_type;
    logic [imhq_pkg::VID_W-1:0] vertex_id;
    logic [imhq_pkg::KEY_W-1:0] new_key;

    modport source (output valid, req_type, vertex_id, new_key, input ready);
    modport sink (input valid, req_type, vertex_id, new_key, output ready);
endinterface

interface imhq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [imhq_pkg::STAT_W-1:0] status;
    logic [imhq_pkg::VID_W-1:0]  res_vertex;
    logic [imhq_pkg::KEY_W-1:0]  res_key;
    logic [imhq_pkg::CNT_W-1:0]  res_count;

    modport source (output valid, status, res_vertex, res_key, res_count, input ready);
    modport sink (input valid, status, res_vertex, res_key, res_count, output ready);
endinterface

// ===== design/imhq_datapath.sv =====
module imhq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  imhq_pkg::t_cmd              i_cmd,
    output imhq_pkg::t_stat             o_stat,
    input  logic [imhq_pkg::REQ_W-1:0]  i_req_type,
    input  logic [imhq_pkg::VID_W-1:0]  i_vertex_id,
    input  logic [imhq_pkg::KEY_W-1:0]  i_new_key,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [imhq_pkg::STAT_W-1:0] o_status,
    output logic [imhq_pkg::VID_W-1:0]  o_res_vertex,
    output logic [imhq_pkg::KEY_W-1:0]  o_res_key,
    output logic [imhq_pkg::CNT_W-1:0]  o_res_count
);
    import imhq_pkg::*;

    // Heap slot s (1-based) lives at address s-1.
    logic [ENTRY_W-1:0] mem_heap [CAPACITY];
    logic [SLOT_W-1:0]  mem_pm [VERTEX_COUNT];

    logic [REQ_W-1:0]   r_req;
    logic [VID_W-1:0]   r_vid;
    logic [KEY_W-1:0]   r_key;
    logic [SLOT_W-1:0]  r_cnt;
    logic [SLOT_W-1:0]  r_s;
    logic [KEY_W-1:0]   r_mk;
    logic [VID_W-1:0]   r_mv;
    logic [KEY_W-1:0]   r_lk;
    logic [VID_W-1:0]   r_lv;
    logic               r_has_r;
    logic [KEY_W-1:0]   r_root_k;
    logic [VID_W-1:0]   r_root_v;
    logic [KEY_W-1:0]   r_res_k;
    logic [VID_W-1:0]   r_res_v;
    logic               r_have_res;
    logic [STAT_W-1:0]  r_status;
    logic [PM_AW-1:0]   r_clr_idx;
    logic [SLOT_W-1:0]  r_pm_rd;
    logic [ENTRY_W-1:0] r_h_rd;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_o_status;
    logic [VID_W-1:0]   r_o_vertex;
    logic [KEY_W-1:0]   r_o_key;
    logic [CNT_W-1:0]   r_o_count;

    logic               h_we, h_re, pm_we;
    logic [HADDR_W-1:0] h_waddr, h_raddr;
    logic [ENTRY_W-1:0] h_wdata;
    logic [PM_AW-1:0]   pm_waddr;
    logic [SLOT_W-1:0]  pm_wdata;
    logic [KEY_W-1:0]   rd_k, ck;
    logic [VID_W-1:0]   rd_v, cv;
    logic [CHILD_W-1:0] c_left, c_right, ci, cnt_x;
    logic               in_range;
    logic [VID_W-1:0]   out_v;
    logic [KEY_W-1:0]   out_k;

    function automatic logic [HADDR_W-1:0] slot_addr(input logic [CHILD_W-1:0] s);
        logic [CHILD_W-1:0] t;
        t = s - 1'b1;
        return t[HADDR_W-1:0];
    endfunction

    assign rd_k     = r_h_rd[ENTRY_W-1:VID_W];
    assign rd_v     = r_h_rd[VID_W-1:0];
    assign c_left   = {r_s, 1'b0};
    assign c_right  = c_left + 1'b1;
    assign cnt_x    = {1'b0, r_cnt};
    assign in_range = 32'(r_vid) < 32'(VERTEX_COUNT);

    // On equal child keys the right child is taken.
    always_comb begin
        if (r_has_r && !(r_lk < rd_k)) begin
            ck = rd_k;
            cv = rd_v;
            ci = c_right;
        end else begin
            ck = r_lk;
            cv = r_lv;
            ci = c_left;
        end
    end

    always_comb begin
        o_stat.clr_done  = r_clr_idx == PM_AW'(VERTEX_COUNT - 1);
        o_stat.in_range  = in_range;
        o_stat.present   = r_pm_rd != '0;
        o_stat.full      = r_cnt == SLOT_W'(CAPACITY);
        o_stat.empty     = r_cnt == '0;
        o_stat.chg_ok    = in_range && (r_pm_rd != '0) && (r_pm_rd <= r_cnt);
        o_stat.cnt_gt1   = r_cnt > SLOT_W'(1);
        o_stat.s_gt1     = r_s > SLOT_W'(1);
        o_stat.up_less   = r_mk < rd_k;
        o_stat.has_child = c_left <= cnt_x;
        o_stat.dn_more   = r_mk > ck;
        o_stat.is_chg    = r_req == REQ_CHANGE;
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.req       = r_req;
    end

    always_comb begin
        h_we    = 1'b0;
        h_waddr = slot_addr({1'b0, r_s});
        h_wdata = {r_mk, r_mv};
        if (i_cmd.up_move) begin
            h_we    = 1'b1;
            h_wdata = r_h_rd;
        end
        if (i_cmd.dn_move) begin
            h_we    = 1'b1;
            h_wdata = {ck, cv};
        end
        if (i_cmd.place) begin
            h_we = 1'b1;
        end

        h_re    = i_cmd.up_rd || i_cmd.ex_root || i_cmd.dn_rdl || i_cmd.dn_rdr;
        h_raddr = slot_addr(c_left);
        if (i_cmd.up_rd) begin
            h_raddr = slot_addr({2'b00, r_s[SLOT_W-1:1]});
        end else if (i_cmd.ex_root) begin
            h_raddr = slot_addr(cnt_x);
        end else if (i_cmd.dn_rdr) begin
            h_raddr = slot_addr(c_right);
        end

        pm_we    = 1'b0;
        pm_waddr = r_mv[PM_AW-1:0];
        pm_wdata = r_s;
        if (i_cmd.clr) begin
            pm_we    = 1'b1;
            pm_waddr = r_clr_idx;
            pm_wdata = '0;
        end else if (i_cmd.ex_root) begin
            pm_we    = 1'b1;
            pm_waddr = r_root_v[PM_AW-1:0];
            pm_wdata = '0;
        end else if (i_cmd.up_move) begin
            pm_we    = 1'b1;
            pm_waddr = rd_v[PM_AW-1:0];
        end else if (i_cmd.dn_move) begin
            pm_we    = 1'b1;
            pm_waddr = cv[PM_AW-1:0];
        end else if (i_cmd.place) begin
            pm_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            mem_heap[h_waddr] <= h_wdata;
        end
        if (h_re) begin
            r_h_rd <= mem_heap[h_raddr];
        end
        if (pm_we) begin
            mem_pm[pm_waddr] <= pm_wdata;
        end
        if (i_cmd.accept) begin
            r_pm_rd <= mem_pm[i_vertex_id[PM_AW-1:0]];
        end
    end

    always_comb begin
        if (r_have_res) begin
            out_v = r_res_v;
            out_k = r_res_k;
        end else if (r_cnt != '0) begin
            out_v = r_root_v;
            out_k = r_root_k;
        end else begin
            out_v = '0;
            out_k = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_have_res  <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.accept) begin
                r_req      <= i_req_type;
                r_vid      <= i_vertex_id;
                r_key      <= i_new_key;
                r_status   <= ST_OK;
                r_have_res <= 1'b0;
            end
            if (i_cmd.st_wr) begin
                r_status <= i_cmd.st_code;
            end
            if (i_cmd.start_ins) begin
                r_cnt <= r_cnt + 1'b1;
                r_s   <= r_cnt + 1'b1;
                r_mk  <= r_key;
                r_mv  <= r_vid;
            end
            if (i_cmd.start_chg) begin
                r_s  <= r_pm_rd;
                r_mk <= r_key;
                r_mv <= r_vid;
            end
            if (i_cmd.ex_root) begin
                r_res_k    <= r_root_k;
                r_res_v    <= r_root_v;
                r_have_res <= 1'b1;
                r_cnt      <= r_cnt - 1'b1;
            end
            if (i_cmd.ex_last) begin
                r_mk <= rd_k;
                r_mv <= rd_v;
                r_s  <= SLOT_W'(1);
            end
            if (i_cmd.up_move) begin
                r_s <= r_s >> 1;
            end
            if (i_cmd.dn_rdr) begin
                r_lk    <= rd_k;
                r_lv    <= rd_v;
                r_has_r <= c_left < cnt_x;
            end
            if (i_cmd.dn_move) begin
                r_s <= ci[SLOT_W-1:0];
            end
            // The root is mirrored so the result needs no extra read.
            if (h_we && h_waddr == '0) begin
                r_root_k <= h_wdata[ENTRY_W-1:VID_W];
                r_root_v <= h_wdata[VID_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_o_status  <= r_status;
                r_o_vertex  <= out_v;
                r_o_key     <= out_k;
                r_o_count   <= CNT_W'(r_cnt);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_res_vertex = r_o_vertex;
    assign o_res_key    = r_o_key;
    assign o_res_count  = r_o_count;

endmodule

// ===== design/imhq_ctrl.sv =====
module imhq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  imhq_pkg::t_stat i_stat,
    output imhq_pkg::t_cmd  o_cmd
);
    import imhq_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_LOOKUP  = 11'b00000000100,
        S_EX_LAST = 11'b00000001000,
        S_UP_RD   = 11'b00000010000,
        S_UP_CMP  = 11'b00000100000,
        S_DN_L    = 11'b00001000000,
        S_DN_R    = 11'b00010000000,
        S_DN_CMP  = 11'b00100000000,
        S_PLACE   = 11'b01000000000,
        S_RESULT  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_RESULT;
                case (i_stat.req)
                    REQ_INSERT: begin
                        o_cmd.st_wr = 1'b1;
                        if (!i_stat.in_range) begin
                            o_cmd.st_code = ST_ABSENT;
                        end else if (i_stat.present) begin
                            o_cmd.st_code = ST_PRESENT;
                        end else if (i_stat.full) begin
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.st_code   = ST_OK;
                            o_cmd.start_ins = 1'b1;
                            n_state         = S_UP_RD;
                        end
                    end
                    REQ_EXTRACT: begin
                        if (i_stat.empty) begin
                            o_cmd.st_wr   = 1'b1;
                            o_cmd.st_code = ST_EMPTY;
                        end else begin
                            o_cmd.ex_root = 1'b1;
                            if (i_stat.cnt_gt1) begin
                                n_state = S_EX_LAST;
                            end
                        end
                    end
                    REQ_CHANGE: begin
                        if (!i_stat.chg_ok) begin
                            o_cmd.st_wr   = 1'b1;
                            o_cmd.st_code = ST_ABSENT;
                        end else begin
                            o_cmd.start_chg = 1'b1;
                            n_state         = S_UP_RD;
                        end
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_EX_LAST: begin
                o_cmd.ex_last = 1'b1;
                n_state       = S_DN_L;
            end
            S_UP_RD: begin
                if (i_stat.s_gt1) begin
                    o_cmd.up_rd = 1'b1;
                    n_state     = S_UP_CMP;
                end else begin
                    n_state = i_stat.is_chg ? S_DN_L : S_PLACE;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_less) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    n_state = i_stat.is_chg ? S_DN_L : S_PLACE;
                end
            end
            S_DN_L: begin
                if (i_stat.has_child) begin
                    o_cmd.dn_rdl = 1'b1;
                    n_state      = S_DN_R;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_R: begin
                o_cmd.dn_rdr = 1'b1;
                n_state      = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_more) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_L;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/indexed_min_heap_queue.sv =====
// One item is in work at a time; each level up costs one heap memory read, each level down two.
// At most log2 of the capacity (10 here) levels are moved up or down per item.
// After reset the position map is cleared, one entry a cycle, all 1024 entries,
// before the first item is accepted.
module indexed_min_heap_queue (
    input logic       i_clk,
    input logic       i_rst_n,
    imhq_req_if.sink  i_req,
    imhq_rsp_if.source o_rsp
);
    import imhq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    imhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    imhq_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req.req_type),
        .i_vertex_id  (i_req.vertex_id),
        .i_new_key    (i_req.new_key),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_res_vertex (o_rsp.res_vertex),
        .o_res_key    (o_rsp.res_key),
        .o_res_count  (o_rsp.res_count)
    );

endmodule

// ===== design/imhq_checker.sv =====
`include "indexed_min_heap_queue_assert.svh"

module imhq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [imhq_pkg::STAT_W-1:0] i_status,
    input logic [imhq_pkg::CNT_W-1:0]  i_count
);
    import imhq_pkg::*;

    `IMHQ_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `IMHQ_ASSERT(a_one_in_work, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)
    `IMHQ_ASSERT(a_count_cap, i_clk, i_rst_n, i_out_valid |-> i_count <= CNT_W'(CAPACITY))
    `IMHQ_ASSERT(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_status == ST_EMPTY |-> i_count == '0)
    `IMHQ_ASSERT(a_full_cap, i_clk, i_rst_n, i_out_valid && i_status == ST_FULL |-> i_count == CNT_W'(CAPACITY))

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_count     (o_rsp.res_count)
);

// ===== tb/imhq_tb_if.sv =====
`timescale 1ns / 100ps

// The interfaces are defined by the design; this file holds the request and response item types.
package imhq_tb_pkg;
    import imhq_pkg::*;

    typedef struct {
        logic [REQ_W-1:0]  req_type;
        logic [VID_W-1:0]  vertex_id;
        logic [KEY_W-1:0]  new_key;
    } t_request;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [VID_W-1:0]  res_vertex;
        logic [KEY_W-1:0]  res_key;
        logic [CNT_W-1:0]  res_count;
    } t_response;
endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import imhq_pkg::*;
    import imhq_tb_pkg::*;

    localparam logic [KEY_W-1:0] KEY_INF = '1;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    imhq_req_if req_ch ();
    imhq_rsp_if rsp_ch ();

    indexed_min_heap_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: heap slots 1..heap_size, vertex to slot map.
    logic [KEY_W-1:0] heap_key [1:CAPACITY];
    logic [VID_W-1:0] heap_vid [1:CAPACITY];
    int               slot_of [VERTEX_COUNT];
    int               heap_size;

    t_response pending_rsp [$];
    int        error_count;
    int        cycle_count;

    initial begin
        req_ch.valid     = 1'b0;
        req_ch.req_type  = '0;
        req_ch.vertex_id = '0;
        req_ch.new_key   = '0;
        rsp_ch.ready     = 1'b0;
        heap_size        = 0;
        error_count      = 0;
        foreach (slot_of[i]) slot_of[i] = 0;
    end

    function automatic void swap_slots(input int a, input int b);
        logic [KEY_W-1:0] k;
        logic [VID_W-1:0] v;
        k = heap_key[a];
        v = heap_vid[a];
        heap_key[a] = heap_key[b];
        heap_vid[a] = heap_vid[b];
        heap_key[b] = k;
        heap_vid[b] = v;
        slot_of[heap_vid[a]] = a;
        slot_of[heap_vid[b]] = b;
    endfunction

    function automatic void bubble_up(inout int s);
        while (s > 1 && heap_key[s] < heap_key[s / 2]) begin
            swap_slots(s, s / 2);
            s = s / 2;
        end
    endfunction

    function automatic void bubble_down(input int s);
        int c;
        while (s * 2 <= heap_size) begin
            c = s * 2;
            // On equal child keys the right child wins.
            if (c < heap_size && !(heap_key[c] < heap_key[c + 1])) c = c + 1;
            if (heap_key[s] > heap_key[c]) begin
                swap_slots(s, c);
                s = c;
            end else begin
                break;
            end
        end
    endfunction

    function automatic t_response apply_request(input t_request rq);
        t_response r;
        int        s;
        bit        extracted;
        r.status     = ST_OK;
        r.res_vertex = '0;
        r.res_key    = KEY_INF;
        extracted    = 1'b0;
        case (rq.req_type)
            REQ_INSERT: begin
                if (slot_of[rq.vertex_id] != 0) begin
                    r.status = ST_PRESENT;
                end else if (heap_size >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    heap_size++;
                    heap_key[heap_size] = rq.new_key;
                    heap_vid[heap_size] = rq.vertex_id;
                    slot_of[rq.vertex_id] = heap_size;
                    s = heap_size;
                    bubble_up(s);
                end
            end
            REQ_EXTRACT: begin
                if (heap_size == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.res_vertex = heap_vid[1];
                    r.res_key    = heap_key[1];
                    extracted    = 1'b1;
                    slot_of[heap_vid[1]] = 0;
                    if (heap_size > 1) begin
                        heap_key[1] = heap_key[heap_size];
                        heap_vid[1] = heap_vid[heap_size];
                        slot_of[heap_vid[1]] = 1;
                    end
                    heap_size--;
                    bubble_down(1);
                end
            end
            REQ_CHANGE: begin
                s = slot_of[rq.vertex_id];
                if (s == 0 || s > heap_size) begin
                    r.status = ST_ABSENT;
                end else begin
                    heap_key[s] = rq.new_key;
                    bubble_up(s);
                    bubble_down(s);
                end
            end
            default: ;
        endcase
        if (!extracted && heap_size > 0) begin
            r.res_vertex = heap_vid[1];
            r.res_key    = heap_key[1];
        end
        r.res_count = CNT_W'(heap_size);
        return r;
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] op, input logic [VID_W-1:0] vid,
                                input logic [KEY_W-1:0] key);
        t_request rq;
        int       gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rq.req_type  = op;
        rq.vertex_id = vid;
        rq.new_key   = key;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.vertex_id <= vid;
        req_ch.new_key   <= key;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.push_back(apply_request(rq));
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Result side: random stalls and comparison with the oldest expectation.
    initial begin
        t_response want;
        int        stall;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected item", 64'd1, 64'd0);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
                if (rsp_ch.res_vertex !== want.res_vertex)
                    report_mismatch("res_vertex", 64'(rsp_ch.res_vertex),
                                    64'(want.res_vertex));
                if (rsp_ch.res_key !== want.res_key)
                    report_mismatch("res_key", 64'(rsp_ch.res_key), 64'(want.res_key));
                if (rsp_ch.res_count !== want.res_count)
                    report_mismatch("res_count", 64'(rsp_ch.res_count),
                                    64'(want.res_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("indexed_min_heap_queue test failed");
            $finish;
        end
    end
    initial cycle_count = 0;

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return KEY_INF;
            1: return '0;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_edges();
        send_request(REQ_EXTRACT, 10'd0, 32'd0);
        send_request(REQ_CHANGE, 10'd5, 32'd1);
        send_request(REQ_INSERT, 10'd1023, KEY_INF);
        send_request(REQ_INSERT, 10'd0, 32'd0);
        send_request(REQ_INSERT, 10'd0, 32'd7);
        send_request(REQ_INSERT, 10'd512, 32'h5555_5555);
        send_request(REQ_INSERT, 10'd341, 32'hAAAA_AAAA);
        send_request(REQ_INSERT, 10'd682, 32'hAAAA_AAAA);
        send_request(REQ_INSERT, 10'd3, 32'd0);
        send_request(REQ_CHANGE, 10'd1023, 32'd0);
        send_request(REQ_CHANGE, 10'd0, KEY_INF);
        send_request(REQ_CHANGE, 10'd100, 32'd3);
        send_request(2'd3, 10'h3FF, KEY_INF);
        repeat (8) send_request(REQ_EXTRACT, 10'd0, 32'd0);
    endtask

    task automatic test_fill_to_capacity();
        for (int v = 0; v < CAPACITY; v++)
            send_request(REQ_INSERT, v[VID_W-1:0], $urandom);
        send_request(REQ_INSERT, 10'd44, 32'd1);
        send_request(REQ_CHANGE, 10'd900, 32'd0);
        send_request(REQ_CHANGE, 10'd17, KEY_INF);
        for (int i = 0; i < 100; i++) send_request(REQ_EXTRACT, 10'd0, 32'd0);
    endtask

    // Mostly valid traffic on a small vertex set so changes usually hit.
    task automatic test_random_mix();
        logic [VID_W-1:0] vid;
        for (int i = 0; i < 150; i++) begin
            vid = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_request(REQ_INSERT, vid, pick_key());
                4, 5, 6:    send_request(REQ_EXTRACT, 10'($urandom), 32'($urandom));
                7, 8:       send_request(REQ_CHANGE, vid, pick_key());
                default:    send_request(2'($urandom), vid, pick_key());
            endcase
        end
    endtask

    initial begin
        int waited;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_fill_to_capacity();
        test_random_mix();
        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_rsp.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            report_mismatch("missing items", 64'(pending_rsp.size()), 64'd0);
        end
        if (error_count == 0) begin
            $display("indexed_min_heap_queue test passed");
        end else begin
            $display("indexed_min_heap_queue test failed");
        end
        $finish;
    end
endmodule
